### hw/rtl/assert_macros.svh
// Assertion macros shared by the timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### hw/rtl/ttt_pkg.sv
// Types and codes shared by the tick timer table modules.
package ttt_pkg;
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_REG   = 2'd1;
	localparam logic [1:0] CMD_UNREG = 2'd2;
	localparam logic [1:0] CMD_UNALL = 2'd3;

	localparam logic [2:0] K_INTERVAL   = 3'd0;
	localparam logic [2:0] K_END        = 3'd1;
	localparam logic [2:0] K_TICK_DONE  = 3'd2;
	localparam logic [2:0] K_REGISTERED = 3'd3;
	localparam logic [2:0] K_DUPLICATE  = 3'd4;
	localparam logic [2:0] K_FULL       = 3'd5;
	localparam logic [2:0] K_UNREG_DONE = 3'd6;

	// controller -> datapath
	typedef struct packed {
		logic load;      // latch input beat
		logic rd;        // issue read of entry at scan index
		logic proc;      // read data valid: evaluate entry
		logic fin;       // scan finished: form summary result
		logic clr_scan;  // reset scan and write indexes
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;  // scan index reached occupancy
		logic ev_pend;   // entry evaluation produced a result
	} dp_sts_t;
endpackage

### hw/rtl/ttt_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module ttt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/ttt_datapath.sv
// Datapath: entry RAM, scan and compaction indexes, result formation.
module ttt_datapath
	import ttt_pkg::*;
#(
	parameter int MAX_TIMERS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd_i,
	output dp_sts_t     sts_o,
	input  logic [1:0]  in_cmd,
	input  logic [15:0] in_key,
	input  logic [15:0] in_target,
	input  logic [15:0] in_total,
	output logic [2:0]  res_kind,
	output logic [15:0] res_key,
	output logic [15:0] res_target,
	output logic [15:0] res_value
);
	localparam int AW = $clog2(MAX_TIMERS);
	localparam int OW = $clog2(MAX_TIMERS + 1);
	localparam int EW = 32 + 2 * COUNT_BITS;

	logic [1:0]  cmd_q;
	logic [15:0] key_q, target_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [OW-1:0] occ_q, ridx_q, widx_q;
	logic dup_q, hit_q;

	logic we;
	logic [AW-1:0] waddr;
	logic [EW-1:0] wdata, rdata;

	ttt_ram #(.WIDTH(EW), .DEPTH(MAX_TIMERS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(ridx_q[AW-1:0]), .rdata(rdata)
	);

	logic [15:0] e_key, e_tgt;
	logic [COUNT_BITS-1:0] e_cnt, e_tot, n_cnt;
	logic adv, drop, match;
	assign e_key = rdata[EW-1 -: 16];
	assign e_tgt = rdata[EW-17 -: 16];
	assign e_cnt = rdata[2*COUNT_BITS-1 -: COUNT_BITS];
	assign e_tot = rdata[COUNT_BITS-1:0];
	assign match = (e_key == key_q) && (e_tgt == target_q);

	always_comb begin
		adv = 1'b0;
		drop = 1'b0;
		n_cnt = e_cnt;
		case (cmd_q)
			CMD_TICK: begin
				adv = e_cnt < e_tot;
				if (adv)
					n_cnt = e_cnt + 1'b1;
				drop = !(n_cnt < e_tot);
			end
			CMD_UNREG: drop = match && !hit_q;
			CMD_UNALL: drop = e_tgt == target_q;
			default: drop = 1'b0;
		endcase
	end

	// Compaction writes kept entries back at the write index; register appends.
	always_comb begin
		we = 1'b0;
		waddr = widx_q[AW-1:0];
		wdata = {e_key, e_tgt, n_cnt, e_tot};
		if (cmd_i.proc && cmd_q != CMD_REG && !drop)
			we = 1'b1;
		if (cmd_i.fin && cmd_q == CMD_REG && !dup_q && occ_q != OW'(MAX_TIMERS)) begin
			we = 1'b1;
			waddr = occ_q[AW-1:0];
			wdata = {key_q, target_q, {COUNT_BITS{1'b0}}, total_q};
		end
	end

	assign sts_o.scan_end = ridx_q == occ_q;
	assign sts_o.ev_pend = cmd_q == CMD_TICK && adv;

	// Totals beyond the count range clamp to the largest count.
	logic [31:0] tot_wide;
	logic [COUNT_BITS-1:0] tot_clamp;
	assign tot_wide = {16'd0, in_total};
	always_comb begin
		if ((tot_wide >> COUNT_BITS) != 32'd0)
			tot_clamp = {COUNT_BITS{1'b1}};
		else
			tot_clamp = tot_wide[COUNT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			ridx_q <= '0;
			widx_q <= '0;
			dup_q <= 1'b0;
			hit_q <= 1'b0;
		end else begin
			if (cmd_i.clr_scan) begin
				ridx_q <= '0;
				widx_q <= '0;
				dup_q <= 1'b0;
				hit_q <= 1'b0;
			end
			if (cmd_i.rd)
				ridx_q <= ridx_q + 1'b1;
			if (cmd_i.proc) begin
				if (cmd_q != CMD_REG && !drop)
					widx_q <= widx_q + 1'b1;
				if (cmd_q == CMD_REG && match)
					dup_q <= 1'b1;
				if (cmd_q == CMD_UNREG && match)
					hit_q <= 1'b1;
			end
			if (cmd_i.fin) begin
				if (cmd_q == CMD_REG) begin
					if (!dup_q && occ_q != OW'(MAX_TIMERS))
						occ_q <= occ_q + 1'b1;
				end else begin
					occ_q <= widx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			cmd_q <= in_cmd;
			key_q <= in_key;
			target_q <= in_target;
			total_q <= tot_clamp;
		end
		if (cmd_i.proc && cmd_q == CMD_TICK) begin
			res_kind <= (n_cnt < e_tot) ? K_INTERVAL : K_END;
			res_key <= e_key;
			res_target <= e_tgt;
			res_value <= 16'(n_cnt);
		end
		if (cmd_i.fin) begin
			case (cmd_q)
				CMD_TICK: begin
					res_kind <= K_TICK_DONE;
					res_key <= '0;
					res_target <= '0;
					res_value <= 16'(occ_q - widx_q);
				end
				CMD_REG: begin
					res_key <= key_q;
					res_target <= target_q;
					res_value <= '0;
					if (dup_q)
						res_kind <= K_DUPLICATE;
					else if (occ_q == OW'(MAX_TIMERS))
						res_kind <= K_FULL;
					else
						res_kind <= K_REGISTERED;
				end
				default: begin
					res_kind <= K_UNREG_DONE;
					res_key <= key_q;
					res_target <= target_q;
					res_value <= 16'(occ_q - widx_q);
				end
			endcase
		end
	end
endmodule

### hw/rtl/ttt_ctrl.sv
// Controller: sequences the table scan and the output handshake.
module ttt_ctrl
	import ttt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output logic    out_last,
	output dp_cmd_t cmd_o,
	input  dp_sts_t sts_i
);
	`include "assert_macros.svh"

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RD   = 6'b000010,
		S_PROC = 6'b000100,
		S_EVT  = 6'b001000,
		S_FIN  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd_o = '0;
		state_d = state_q;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd_o.load = 1'b1;
					cmd_o.clr_scan = 1'b1;
					state_d = S_RD;
				end
			end
			S_RD: begin
				if (sts_i.scan_end) begin
					state_d = S_FIN;
				end else begin
					cmd_o.rd = 1'b1;
					state_d = S_PROC;
				end
			end
			S_PROC: begin
				cmd_o.proc = 1'b1;
				state_d = sts_i.ev_pend ? S_EVT : S_RD;
			end
			S_EVT: begin
				out_valid = 1'b1;
				if (out_ready)
					state_d = S_RD;
			end
			S_FIN: begin
				cmd_o.fin = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				out_last = 1'b1;
				if (out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`ASSERT_IMPL(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`ASSERT_IMPL(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`ASSERT_NEXT(a_fin_out, clk, arst_n, cmd_o.fin, out_valid && out_last)
endmodule

### hw/rtl/tick_timer_table_unit.sv
// Tick timer table top level: stream ports around controller and datapath.
// One command beat at a time. Each command scans the occupied entries, each
// with a RAM read and then an evaluate and compact-write, emits a beat for each
// tick event, and ends with scan end, summary and final beat; a new input beat
// is accepted only after the final beat is taken. Timers are kept in a single
// RAM of MAX_TIMERS entries; no clearing pass is needed.
module tick_timer_table_unit
	import ttt_pkg::*;
#(
	parameter int MAX_TIMERS = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // cmd[1:0], key_id[17:2], target_id[33:18],
	                               // total_ticks[49:34], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // kind[2:0], ev_key[18:3], ev_target[34:19],
	                               // value[50:35], zero pad
	output logic        m_tlast
);
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic [2:0]  kind;
	logic [15:0] ev_key, ev_target, value;

	ttt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_last(m_tlast),
		.cmd_o(cmd), .sts_i(sts)
	);

	ttt_datapath #(.MAX_TIMERS(MAX_TIMERS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(cmd), .sts_o(sts),
		.in_cmd(s_tdata[1:0]), .in_key(s_tdata[17:2]),
		.in_target(s_tdata[33:18]), .in_total(s_tdata[49:34]),
		.res_kind(kind), .res_key(ev_key), .res_target(ev_target), .res_value(value)
	);

	assign m_tdata = {5'd0, value, ev_target, ev_key, kind};
endmodule

### bench/tick_timer_table_unit_test.sv
// Testbench for the tick timer table: directed and random commands with a scoreboard.
`timescale 1ns / 1ps
module tick_timer_table_unit_test
	import ttt_pkg::*;
();

	localparam int TIMER_SLOTS = 16;

	typedef struct {
		logic [2:0]  kind;
		logic [15:0] ev_key;
		logic [15:0] ev_target;
		logic [15:0] value;
		logic        last;
	} event_t;

	typedef struct {
		logic [15:0] key;
		logic [15:0] target;
		logic [15:0] count;
		logic [15:0] total;
	} timer_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;
	logic        m_tlast;

	timer_t timers[TIMER_SLOTS];
	int     timer_count;
	event_t expected_events[$];
	int     mismatch_count;
	int     hold_cycles;
	bit     stall_enable;
	bit     long_hold;
	event   long_hold_start;

	tick_timer_table_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("t=%0t %s: got %0h expected %0h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic void push_event(input logic [2:0] kind, input logic [15:0] key,
			input logic [15:0] target, input logic [15:0] value, input logic last);
		event_t e;
		e.kind = kind; e.ev_key = key; e.ev_target = target;
		e.value = value; e.last = last;
		expected_events = {expected_events, e};
	endfunction

	// Drop marked timers, keep order; return number removed.
	function automatic int compact_timers(input bit drop[TIMER_SLOTS]);
		int w;
		int n;
		w = 0;
		n = timer_count;
		for (int i = 0; i < n; i++) begin
			if (!drop[i]) begin
				timers[w] = timers[i];
				w++;
			end
		end
		timer_count = w;
		return n - w;
	endfunction

	function automatic void predict_command(input logic [1:0] cmd, input logic [15:0] key,
			input logic [15:0] target, input logic [15:0] total);
		bit drop[TIMER_SLOTS];
		bit dup;
		int removed;
		dup = 1'b0;
		foreach (drop[i]) drop[i] = 1'b0;
		case (cmd)
			CMD_TICK: begin
				for (int i = 0; i < timer_count; i++) begin
					if (timers[i].count < timers[i].total) begin
						timers[i].count = timers[i].count + 16'd1;
						push_event(timers[i].count < timers[i].total ? K_INTERVAL : K_END,
							timers[i].key, timers[i].target, timers[i].count, 1'b0);
					end
					if (timers[i].count >= timers[i].total) drop[i] = 1'b1;
				end
				removed = compact_timers(drop);
				push_event(K_TICK_DONE, 16'd0, 16'd0, removed[15:0], 1'b1);
			end
			CMD_REG: begin
				for (int i = 0; i < timer_count; i++)
					if (timers[i].key == key && timers[i].target == target) dup = 1'b1;
				if (dup) begin
					push_event(K_DUPLICATE, key, target, 16'd0, 1'b1);
				end else if (timer_count >= TIMER_SLOTS) begin
					push_event(K_FULL, key, target, 16'd0, 1'b1);
				end else begin
					timers[timer_count] = '{key, target, 16'd0, total};
					timer_count++;
					push_event(K_REGISTERED, key, target, 16'd0, 1'b1);
				end
			end
			CMD_UNREG: begin
				for (int i = 0; i < timer_count; i++) begin
					if (!dup && timers[i].key == key && timers[i].target == target) begin
						drop[i] = 1'b1;
						dup = 1'b1;
					end
				end
				removed = compact_timers(drop);
				push_event(K_UNREG_DONE, key, target, removed[15:0], 1'b1);
			end
			default: begin
				for (int i = 0; i < timer_count; i++)
					if (timers[i].target == target) drop[i] = 1'b1;
				removed = compact_timers(drop);
				push_event(K_UNREG_DONE, key, target, removed[15:0], 1'b1);
			end
		endcase
	endfunction

	task automatic send_command(input logic [1:0] cmd, input logic [15:0] key,
			input logic [15:0] target, input logic [15:0] total);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		// the block is never ready right after a beat, so the wait before the next beat is never skipped
		repeat (gap + 1) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, total, target, key, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_command(cmd, key, target, total);
		s_tvalid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_events.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Long receiver hold, counted in cycles.
	always begin
		@(long_hold_start);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Output side: random stalls, or a long hold when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (long_hold) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else if (stall_enable) begin
			if ($urandom_range(0, 19) == 0) hold_cycles <= $urandom_range(10, 60);
			m_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		event_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected beat", {13'd0, m_tdata[2:0]}, 16'd0);
			end else begin
				want = expected_events.pop_front();
				if (m_tdata[2:0] != want.kind)
					report_mismatch("kind", {13'd0, m_tdata[2:0]}, {13'd0, want.kind});
				if (m_tdata[18:3] != want.ev_key)
					report_mismatch("ev_key", m_tdata[18:3], want.ev_key);
				if (m_tdata[34:19] != want.ev_target)
					report_mismatch("ev_target", m_tdata[34:19], want.ev_target);
				if (m_tdata[50:35] != want.value)
					report_mismatch("value", m_tdata[50:35], want.value);
				if (m_tlast != want.last)
					report_mismatch("last", {15'd0, m_tlast}, {15'd0, want.last});
			end
		end
	end

	task automatic test_directed();
		send_command(CMD_TICK, 16'd0, 16'd0, 16'd0);
		send_command(CMD_REG, 16'hFFFF, 16'hFFFF, 16'd0);
		send_command(CMD_REG, 16'h0000, 16'h0000, 16'hFFFF);
		send_command(CMD_REG, 16'h0000, 16'h0000, 16'd3);
		send_command(CMD_REG, 16'h1234, 16'h00AA, 16'd1);
		send_command(CMD_REG, 16'h5678, 16'h00AA, 16'd2);
		send_command(CMD_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_command(CMD_TICK, 16'd0, 16'd0, 16'd0);
		send_command(CMD_UNREG, 16'h9999, 16'h9999, 16'd0);
		send_command(CMD_UNREG, 16'h0000, 16'h0000, 16'd0);
		for (int i = 0; i < 17; i++)
			send_command(CMD_REG, i[15:0], 16'h0055, 16'd2 + i[15:0]);
		wait_drained();
	endtask

	task automatic test_fill_and_stall();
		// table is full here: duplicate wins over full
		send_command(CMD_REG, 16'd3, 16'h0055, 16'd1);
		send_command(CMD_REG, 16'hAAAA, 16'h5555, 16'd1);
		-> long_hold_start;
		for (int i = 0; i < 4; i++) send_command(CMD_TICK, 16'd0, 16'd0, 16'd0);
		wait_drained();
		send_command(CMD_UNALL, 16'h0001, 16'h0055, 16'd0);
		send_command(CMD_UNALL, 16'h0001, 16'h0055, 16'd0);
		wait_drained();
	endtask

	task automatic test_random(input int items);
		logic [1:0]  cmd;
		logic [15:0] key;
		logic [15:0] target;
		logic [15:0] total;
		int          r;
		for (int n = 0; n < items; n++) begin
			r = $urandom_range(0, 99);
			cmd = r < 40 ? CMD_TICK : r < 75 ? CMD_REG : r < 92 ? CMD_UNREG : CMD_UNALL;
			// small id pools so duplicates and matches happen
			if ($urandom_range(0, 4) == 0) begin
				key = 16'($urandom);
				target = 16'($urandom);
			end else begin
				key = 16'($urandom_range(0, 7));
				target = 16'($urandom_range(0, 3));
			end
			if ($urandom_range(0, 9) == 0)
				total = 16'($urandom);
			else
				total = 16'($urandom_range(0, 6));
			send_command(cmd, key, target, total);
			if (n % 60 == 59) wait_drained();
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		timer_count = 0;
		mismatch_count = 0;
		hold_cycles = 0;
		stall_enable = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_fill_and_stall();
		test_random(100);
		stall_enable = 1'b0;
		test_random(50);
		stall_enable = 1'b1;
		test_random(45);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
